// ----- rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// shared constants and types for the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;
  localparam int COLS_DEF     = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_COLS_DEF = 4;
  localparam int TAB_ROWS_DEF = 4;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_SETPOS = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_HT = 8'h09;
  localparam logic [7:0] CH_VT = 8'h0B;

  localparam logic [7:0] COLOUR_RESET = 8'h0E;

  // classified command handed from front to back
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_code;
    logic [6:0] col;
    logic [4:0] row;
  } tcw_op_t;
endpackage

// ----- rtl/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- rtl/tcw_front.sv -----
// ----------------------------------------------------------------------------
// tcw_front
// accepts commands, saturates positions, holds a two entry queue
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [1:0]       cmd,
  input  logic [7:0]       char_code,
  input  logic [6:0]       col,
  input  logic [4:0]       row,
  output logic             full,
  output logic             q_valid,
  output tcw_pkg::tcw_op_t q_op,
  input  logic             pop
);
  tcw_pkg::tcw_op_t ent_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic rd_r, wr_r;
  tcw_pkg::tcw_op_t op_in;

  always_comb begin
    op_in.cmd = cmd;
    op_in.char_code = char_code;
    op_in.col = ({25'd0, col} > COLS - 1) ? 7'(COLS - 1) : col;
    op_in.row = ({27'd0, row} > ROWS - 1) ? 5'(ROWS - 1) : row;
  end

  assign full    = cnt_r == 2'd2;
  assign q_valid = cnt_r != 2'd0;
  assign q_op    = ent_r[rd_r];
  assign cnt_nxt = cnt_r + 2'(push && !full) - 2'(pop && q_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push && !full) begin
        wr_r <= !wr_r;
      end
      if (pop && q_valid) begin
        rd_r <= !rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      ent_r[wr_r] <= op_in;
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
endmodule

// ----- rtl/tcw_back.sv -----
// ----------------------------------------------------------------------------
// tcw_back
// executes commands against the cell store, walks scroll and clear
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int COLS     = tcw_pkg::COLS_DEF,
  parameter int ROWS     = tcw_pkg::ROWS_DEF,
  parameter int TAB_COLS = tcw_pkg::TAB_COLS_DEF,
  parameter int TAB_ROWS = tcw_pkg::TAB_ROWS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       colour,
  input  logic             q_valid,
  input  tcw_pkg::tcw_op_t q_op,
  output logic             pop,
  output logic             idle,
  output logic             out_valid,
  output logic [6:0]       out_cursor_col,
  output logic [4:0]       out_cursor_row,
  output logic [10:0]      out_cursor_offset,
  output logic [7:0]       out_cell_char,
  output logic [7:0]       out_cell_colour
);
  localparam int NCELLS = COLS * ROWS;
  localparam int AW = $clog2(NCELLS);
  localparam int CW = 24;  // wide enough for sums before wrap

  localparam logic [2:0] S_INIT = 3'd0, S_IDLE = 3'd1, S_MRD = 3'd2,
                         S_MWR = 3'd3, S_BLANK = 3'd4, S_RD1 = 3'd5,
                         S_RD2 = 3'd6;

  logic [2:0]  st_r, st_nxt;
  logic [AW-1:0] idx_r, idx_nxt;     // destination index of sweep
  logic [AW:0]   shift_r, shift_nxt; // lines * COLS
  logic [6:0]  ccol_r, ccol_nxt;
  logic [4:0]  crow_r, crow_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  rch_r, rch_nxt, rco_r, rco_nxt;

  logic          we;
  logic [AW-1:0] addr;
  logic [15:0]   wdata, rdata;

  tcw_ram #(.WIDTH(16), .DEPTH(NCELLS)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // put-character cursor math
  logic [CW-1:0] pc, pr, cell_a;
  logic [CW-1:0] shift_w;
  logic          wr_char;
  always_comb begin
    pc = CW'(ccol_r);
    pr = CW'(crow_r);
    wr_char = 1'b0;
    case (q_op.char_code)
      tcw_pkg::CH_LF: pr = pr + CW'(1);
      tcw_pkg::CH_CR: pc = '0;
      tcw_pkg::CH_HT: pc = pc + CW'(TAB_COLS);
      tcw_pkg::CH_VT: pr = pr + CW'(TAB_ROWS);
      default: begin
        wr_char = 1'b1;
        pc = pc + CW'(1);
      end
    endcase
    if (pc >= CW'(COLS)) begin
      pr = pr + CW'(1);
      pc = pc - CW'(COLS);
      if (pc >= CW'(COLS)) pc = CW'(COLS - 1);
    end
    shift_w = '0;
    if (pr >= CW'(ROWS)) begin
      shift_w = (pr - CW'(ROWS - 1)) * CW'(COLS);
      if (pr - CW'(ROWS - 1) >= CW'(ROWS)) shift_w = CW'(NCELLS);
      pr = CW'(ROWS - 1);
    end
    cell_a = CW'(crow_r) * CW'(COLS) + CW'(ccol_r);
  end

  logic [CW-1:0] src;
  assign src = CW'(idx_r) + CW'(shift_r);

  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; shift_nxt = shift_r;
    ccol_nxt = ccol_r; crow_nxt = crow_r; ov_nxt = 1'b0;
    rch_nxt = 8'd0; rco_nxt = 8'd0;
    we = 1'b0; addr = idx_r; wdata = {colour, 8'd0};
    pop = 1'b0;
    case (st_r)
      S_INIT: begin
        we = 1'b1; wdata = '0;
        idx_nxt = idx_r + AW'(1);
        if (CW'(idx_r) == CW'(NCELLS - 1)) begin
          st_nxt = S_IDLE;
          idx_nxt = '0;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          case (q_op.cmd)
            tcw_pkg::CMD_PUT: begin
              if (wr_char) begin
                we = 1'b1; addr = cell_a[AW-1:0];
                wdata = {colour, q_op.char_code};
              end
              ccol_nxt = pc[6:0]; crow_nxt = pr[4:0];
              idx_nxt = '0;
              shift_nxt = shift_w[AW:0];
              if (shift_w == '0) ov_nxt = 1'b1;
              else if (shift_w >= CW'(NCELLS)) st_nxt = S_BLANK;
              else st_nxt = S_MRD;
            end
            tcw_pkg::CMD_CLEAR: begin
              ccol_nxt = '0; crow_nxt = '0; idx_nxt = '0;
              shift_nxt = (AW+1)'(NCELLS);
              st_nxt = S_BLANK;
            end
            tcw_pkg::CMD_SETPOS: begin
              ccol_nxt = q_op.col; crow_nxt = q_op.row; ov_nxt = 1'b1;
            end
            default: begin
              addr = AW'(CW'(q_op.row) * CW'(COLS) + CW'(q_op.col));
              st_nxt = S_RD1;
            end
          endcase
        end
      end
      S_RD1: begin
        rch_nxt = rdata[7:0]; rco_nxt = rdata[15:8];
        ov_nxt = 1'b1; st_nxt = S_IDLE;
      end
      S_MRD: begin
        addr = src[AW-1:0];
        st_nxt = S_MWR;
      end
      S_MWR: begin
        we = 1'b1; wdata = rdata;
        idx_nxt = idx_r + AW'(1);
        st_nxt = (src == CW'(NCELLS - 1)) ? S_BLANK : S_MRD;
      end
      S_BLANK: begin
        we = 1'b1;
        idx_nxt = idx_r + AW'(1);
        if (CW'(idx_r) == CW'(NCELLS - 1)) begin
          st_nxt = S_IDLE; ov_nxt = 1'b1; idx_nxt = '0;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT; idx_r <= '0; shift_r <= '0;
      ccol_r <= '0; crow_r <= '0; ov_r <= 1'b0;
      rch_r <= '0; rco_r <= '0;
    end else begin
      st_r <= st_nxt; idx_r <= idx_nxt; shift_r <= shift_nxt;
      ccol_r <= ccol_nxt; crow_r <= crow_nxt; ov_r <= ov_nxt;
      rch_r <= rch_nxt; rco_r <= rco_nxt;
    end
  end

  assign idle = (st_r == S_IDLE) && !q_valid;
  assign out_valid = ov_r;
  assign out_cursor_col = ccol_r;
  assign out_cursor_row = crow_r;
  assign out_cursor_offset = 11'(CW'(crow_r) * CW'(COLS) + CW'(ccol_r));
  assign out_cell_char = rch_r;
  assign out_cell_colour = rco_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> st_r == S_IDLE) else $error("pop outside idle");
  a_rd: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_RD1 |=> out_valid) else $error("read without result");
  a_col: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(ccol_r) < CW'(COLS)) else $error("cursor column out of range");
endmodule

// ----- rtl/text_console_writer_core.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_core
// text console engine over a cols x rows character/colour cell store
// ----------------------------------------------------------------------------
// sequence: a scroll copies each moved cell, then blanks the rest; a clear
// blanks every cell; all store access goes through the single ram port
// throughput: one command per cycle when no scroll, clear or read is under
// way; a read holds the next command back until its result is registered
// reset: cursor to 0, colour to 14, then a clearing pass zeroes the store;
// commands queue two deep meanwhile; results cannot stall
module text_console_writer_core #(
  parameter int COLS     = tcw_pkg::COLS_DEF,
  parameter int ROWS     = tcw_pkg::ROWS_DEF,
  parameter int TAB_COLS = tcw_pkg::TAB_COLS_DEF,
  parameter int TAB_ROWS = tcw_pkg::TAB_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_char_code,
  input  logic [6:0]  in_col,
  input  logic [4:0]  in_row,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output logic        out_valid,
  output logic [6:0]  out_cursor_col,
  output logic [4:0]  out_cursor_row,
  output logic [10:0] out_cursor_offset,
  output logic [7:0]  out_cell_char,
  output logic [7:0]  out_cell_colour
);
  // colour register
  logic [7:0] colour_r;
  always_ff @(posedge clk) begin
    if (!rst_n) colour_r <= tcw_pkg::COLOUR_RESET;
    else if (cfg_we) colour_r <= cfg_wdata;
  end

  logic full, q_valid, pop, idle;
  tcw_pkg::tcw_op_t q_op;

  // busy while the queue is full; a transfer is start && !busy
  assign busy = full;

  tcw_front #(.COLS(COLS), .ROWS(ROWS)) u_front (
    .clk(clk), .rst_n(rst_n), .push(start), .cmd(in_cmd),
    .char_code(in_char_code), .col(in_col), .row(in_row),
    .full(full), .q_valid(q_valid), .q_op(q_op), .pop(pop)
  );

  tcw_back #(.COLS(COLS), .ROWS(ROWS), .TAB_COLS(TAB_COLS),
             .TAB_ROWS(TAB_ROWS)) u_back (
    .clk(clk), .rst_n(rst_n), .colour(colour_r), .q_valid(q_valid),
    .q_op(q_op), .pop(pop), .idle(idle), .out_valid(out_valid),
    .out_cursor_col(out_cursor_col), .out_cursor_row(out_cursor_row),
    .out_cursor_offset(out_cursor_offset), .out_cell_char(out_cell_char),
    .out_cell_colour(out_cell_colour)
  );

  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    idle |-> !busy) else $error("busy while idle");
endmodule
